FILE: hdl/mhi_pkg.sv
// Shared types and constants for the max-heap insert engine.
// Used by mhi_store and max_heap_insert_sift_up; no dependencies.
`default_nettype none
package mhi_pkg;

  localparam int PRIO_W       = 32;
  localparam int ITEM_W       = 32;
  localparam int SWAP_W       = 4;
  localparam int DEF_CAPACITY = 2048;
  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [ITEM_W-1:0] item;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/max_heap_insert_sift_up.sv
// Top level of the binary max-heap insert engine with sift-up.
// Depends on mhi_pkg and mhi_store.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: a signed priority
//   and an item value. Output channel (out_valid/out_ready) returns one word
//   per input: the number of parent swaps and an overflow flag.
//   The new entry is held in a register while a hole walks up the tree:
//   each level reads the parent from the store (registered read data) and,
//   when the new priority is strictly greater, writes the parent down one
//   level while the grandparent read is issued in the same cycle.
//   One item is in work at a time: the next word is accepted only after the
//   result of the last one loads into the output register and the engine
//   returns to idle.
//   A full heap drops the word and reports overflow with swap count 0.
//   Reset clears the entry count and the handshake state; store contents
//   are not cleared and are never read before being written.
//   A stalled receiver holds the result in the output register; the next
//   word is accepted meanwhile and waits in its final state for the slot.
`default_nettype none
module max_heap_insert_sift_up
  import mhi_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [PRIO_W-1:0] in_priority_req,
  input  wire logic signed [ITEM_W-1:0] in_item_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [SWAP_W-1:0]             out_swap_count,
  output logic                          out_overflow
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            slot_r, slot_nxt;
  logic [SWAP_W-1:0]        swaps_r, swaps_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic signed [ITEM_W-1:0] item_r, item_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SWAP_W-1:0]        out_swaps_r, out_swaps_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic          accept, full, greater, out_free;
  logic [CW-1:0] new_slot, parent, new_parent;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  mhi_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid && in_ready;
  assign full           = (count_r == CAP_C);
  assign new_slot       = count_r + ONE_C;
  assign new_parent     = new_slot >> 1;
  assign parent         = slot_r >> 1;
  assign greater        = (prio_r > rd_data.prio);
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_swap_count = out_swaps_r;
  assign out_overflow   = out_ovf_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_nxt = ST_DONE;
          end else if (count_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (greater) begin
          state_nxt = (parent == ONE_C) ? ST_PLACE : ST_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PLACE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    swaps_nxt     = swaps_r;
    ovf_nxt       = ovf_r;
    prio_nxt      = prio_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_swaps_nxt = out_swaps_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = AW'(slot_r - ONE_C);
    wr_data       = '{prio: prio_r, item: item_r};
    rd_en         = 1'b0;
    rd_addr       = AW'(new_parent - ONE_C);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prio_nxt  = in_priority_req;
          item_nxt  = in_item_value;
          swaps_nxt = '0;
          ovf_nxt   = full;
          if (!full) begin
            count_nxt = new_slot;
            slot_nxt  = new_slot;
            rd_en     = (count_r != '0);
          end
        end
      end
      ST_CMP: begin
        wr_en = 1'b1;
        if (greater) begin
          wr_data  = rd_data;
          slot_nxt = parent;
          if (swaps_r != SWAP_MAX) begin
            swaps_nxt = swaps_r + SWAP_W'(1);
          end
          rd_en   = (parent != ONE_C);
          rd_addr = AW'((parent >> 1) - ONE_C);
        end
      end
      ST_PLACE: wr_en = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_swaps_nxt = ovf_r ? '0 : swaps_r;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    swaps_r     <= swaps_nxt;
    ovf_r       <= ovf_nxt;
    prio_r      <= prio_nxt;
    item_r      <= item_nxt;
    out_swaps_r <= out_swaps_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_cmp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> slot_r >= CW'(2))
    else $error("compare state at root slot");

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write to the same entry in one cycle");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_swaps_r == '0)
    else $error("overflow result with nonzero swap count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full |=> count_r == $past(count_r) + ONE_C)
    else $error("entry count did not advance on insert");

endmodule
`default_nettype wire

FILE: hdl/mhi_store.sv
// Heap entry store: one write port, one read port, registered read data.
// Depends on mhi_pkg for entry_t.
`default_nettype none
module mhi_store
  import mhi_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: bench/max_heap_insert_sift_up_tb.sv
// Self-checking testbench for max_heap_insert_sift_up: fills the heap past capacity
// and checks every swap count and overflow flag against an in-bench copy of the heap.
// Depends on mhi_pkg and the max_heap_insert_sift_up RTL.
`default_nettype none
module max_heap_insert_sift_up_tb;
  import mhi_pkg::*;

  localparam int HEAP_DEPTH = DEF_CAPACITY;
  localparam int N_DIRECTED = 18;
  localparam int N_OVERFLOW = 40;
  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN   = 400;
  localparam logic signed [PRIO_W-1:0] PRIO_TOP = 32'sh7fff_ffff;
  localparam logic signed [PRIO_W-1:0] PRIO_BOT = 32'sh8000_0000;

  typedef struct packed {
    logic [SWAP_W-1:0] swaps;
    logic              ovf;
  } insert_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic signed [ITEM_W-1:0] in_item_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SWAP_W-1:0] out_swap_count;
  logic out_overflow;

  logic signed [PRIO_W-1:0] heap_prio [HEAP_DEPTH];
  logic signed [ITEM_W-1:0] heap_item [HEAP_DEPTH];
  int heap_size = 0;

  entry_t         pending_words [$];
  insert_result_t expected_results [$];
  int   err_count = 0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   hold_left = 0;
  logic hold_armed = 1'b1;
  logic [31:0] cyc = '0;
  logic signed [PRIO_W-1:0] ramp_prio = '0;

  max_heap_insert_sift_up #(.CAPACITY(HEAP_DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_priority_req(in_priority_req),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_swap_count (out_swap_count),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic insert_result_t heap_insert(input logic signed [PRIO_W-1:0] p,
                                                 input logic signed [ITEM_W-1:0] v);
    insert_result_t r;
    int slot;
    logic signed [PRIO_W-1:0] tp;
    logic signed [ITEM_W-1:0] ti;
    r = '0;
    if (heap_size >= HEAP_DEPTH) begin
      r.ovf = 1'b1;
      return r;
    end
    heap_size++;
    slot = heap_size;
    heap_prio[slot-1] = p;
    heap_item[slot-1] = v;
    while (slot > 1 && heap_prio[slot-1] > heap_prio[slot/2-1]) begin
      tp = heap_prio[slot-1];
      ti = heap_item[slot-1];
      heap_prio[slot-1] = heap_prio[slot/2-1];
      heap_item[slot-1] = heap_item[slot/2-1];
      heap_prio[slot/2-1] = tp;
      heap_item[slot/2-1] = ti;
      slot = slot / 2;
      if (r.swaps != SWAP_MAX) r.swaps++;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (cyc[9:8] == 2'b00) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // keep the top value free so the last slot can climb the full depth
  function automatic logic signed [PRIO_W-1:0] rand_prio();
    logic signed [PRIO_W-1:0] p;
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 40) begin
      p = $urandom();
    end else if (mode < 60) begin
      p = $signed($urandom_range(0, 8)) - 4;
    end else if (mode < 80) begin
      ramp_prio = ramp_prio + $urandom_range(1, 1000);
      p = ramp_prio;
    end else if (mode < 90) begin
      case ($urandom_range(0, 3))
        0: p = PRIO_BOT;
        1: p = PRIO_TOP - 1;
        2: p = -1;
        default: p = 0;
      endcase
    end else begin
      ramp_prio = ramp_prio - $urandom_range(1, 1000);
      p = ramp_prio;
    end
    if (p == PRIO_TOP) p = PRIO_TOP - 1;
    return p;
  endfunction

  task automatic add_word(input logic signed [PRIO_W-1:0] p,
                          input logic signed [ITEM_W-1:0] v);
    entry_t e;
    e.prio = p;
    e.item = v;
    pending_words.push_back(e);
  endtask

  initial begin
    add_word(PRIO_BOT, 32'sh0000_0000);
    add_word(PRIO_BOT, 32'shffff_ffff);
    add_word(PRIO_TOP - 1, 32'sh7fff_ffff);
    add_word(PRIO_TOP - 1, 32'sh8000_0000);
    add_word(-1, 32'sh5555_5555);
    add_word(0, 32'shaaaa_aaaa);
    add_word(-2, 32'sh0000_0001);
    add_word(1, 32'sh1234_5678);
    add_word(32'sh8000_0001, 32'shdead_beef);
    add_word(-5, 32'sh0f0f_0f0f);
    add_word(-4, 32'shf0f0_f0f0);
    add_word(-3, 32'sh3333_3333);
    add_word(2, 32'shcccc_cccc);
    add_word(3, 32'sh0000_ffff);
    add_word(4, 32'shffff_0000);
    add_word(PRIO_TOP - 1, 32'sh0000_0002);
    add_word(32'sh4000_0000, 32'sh7fff_fffe);
    add_word(32'shc000_0000, 32'sh8000_0001);
    repeat (HEAP_DEPTH - N_DIRECTED - 1) add_word(rand_prio(), $urandom());
    add_word(PRIO_TOP, 32'sh0bad_cafe);
    add_word(PRIO_TOP, PRIO_TOP);
    add_word(PRIO_BOT, PRIO_BOT);
    repeat (N_OVERFLOW - 2) add_word($urandom(), $urandom());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) cyc <= '0;
    else cyc <= cyc + 1;
  end

  always @(posedge clk) begin : drive_p
    entry_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(heap_insert(in_priority_req, in_item_value));
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_priority_req <= w.prio;
          in_item_value <= w.item;
          send_gap = pick_gap();
        end
      end
    end
  end

  // hold off the receiver long enough for the block to back up its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && cyc == HOLD_START) begin
      hold_left <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_p
    insert_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word swap_count %0d overflow %0b", $time,
                   out_swap_count, out_overflow);
          err_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_swap_count !== e.swaps) begin
            $display("%0t: swap_count expected %0d actual %0d", $time, e.swaps,
                     out_swap_count);
            err_count++;
          end
          if (out_overflow !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, out_overflow);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) recv_stall = pick_gap();
      end
    end
  end

endmodule
`default_nettype wire
